// File: hw/rtl/nrmc_pkg.sv
// Shared types, character codes and tables for the RMC position parser.
package nrmc_pkg;

  localparam int AccW    = 31;  // field magnitude, saturates at 2^31-1
  localparam int CharsW  = 4;   // characters counted per field
  localparam int FracW   = 3;   // fraction digits kept per field
  localparam int PowW    = 17;  // wide enough for 10^5
  localparam int ValueW  = 32;
  localparam int StatusW = 3;

  localparam logic [AccW-1:0] SatMax = {AccW{1'b1}};

  localparam logic [7:0] ChDollar = 8'h24;  // '$'
  localparam logic [7:0] ChComma  = 8'h2c;  // ','
  localparam logic [7:0] ChPoint  = 8'h2e;  // '.'
  localparam logic [7:0] ChZero   = 8'h30;  // '0'
  localparam logic [7:0] ChNine   = 8'h39;  // '9'
  localparam logic [7:0] ChA      = 8'h41;  // 'A'
  localparam logic [7:0] ChC      = 8'h43;  // 'C'
  localparam logic [7:0] ChE      = 8'h45;  // 'E'
  localparam logic [7:0] ChG      = 8'h47;  // 'G'
  localparam logic [7:0] ChM      = 8'h4d;  // 'M'
  localparam logic [7:0] ChN      = 8'h4e;  // 'N'
  localparam logic [7:0] ChP      = 8'h50;  // 'P'
  localparam logic [7:0] ChR      = 8'h52;  // 'R'
  localparam logic [7:0] ChS      = 8'h53;  // 'S'
  localparam logic [7:0] ChW      = 8'h57;  // 'W'

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_HDR0  = 4'd1,
    PH_HDR1  = 4'd2,
    PH_HDR2  = 4'd3,
    PH_HDR3  = 4'd4,
    PH_HDR4  = 4'd5,
    PH_HDR5  = 4'd6,
    PH_SKIP  = 4'd7,
    PH_DROP  = 4'd8,
    PH_LAT   = 4'd9,
    PH_NS    = 4'd10,
    PH_COMMA = 4'd11,
    PH_LON   = 4'd12,
    PH_EW    = 4'd13
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_HEADER    = 3'd1,
    ST_BAD_NS    = 3'd2,
    ST_NO_COMMA  = 3'd3,
    ST_BAD_EW    = 3'd4
  } status_e;

  // Per-field gather state, shared by latitude and longitude.
  typedef struct packed {
    logic [CharsW-1:0] chars;
    logic [FracW-1:0]  frac;
    logic              point;
    logic              stopped;
  } field_t;

  typedef struct packed {
    logic [ValueW-1:0] lat;
    logic [ValueW-1:0] lon;
    status_e           status;
  } result_t;

  // Expected header character ("GPRMC,") for each header phase.
  function automatic logic [7:0] hdr_char(input phase_e ph);
    logic [7:0] c;
    case (ph)
      PH_HDR0: c = ChG;
      PH_HDR1: c = ChP;
      PH_HDR2: c = ChR;
      PH_HDR3: c = ChM;
      PH_HDR4: c = ChC;
      PH_HDR5: c = ChComma;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [PowW-1:0] pow10(input logic [FracW-1:0] k);
    logic [PowW-1:0] p;
    case (k)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      3'd5:    p = 17'd100000;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

endpackage

// File: hw/rtl/nmea_rmc_position_parser.sv
// Top level: NMEA RMC position parser with input and result registers.
//
//   channel | valid      | ready      | payload
//   --------+------------+------------+---------------------------------------------
//   in      | in_valid_i | in_ready_o | rx_byte_i
//   out     | out_valid_o| out_ready_i| latitude_value_o, longitude_value_o,
//           |            |            | parse_status_o
//
// One byte per cycle sustained unless a sentence end waits on a full result register;
// out_valid_o rises once the byte closing its sentence has passed the input register
// and the result register. The state machine processes the byte in the input register.
// It waits only if it closes a sentence while the result register is still full.
// Reset returns the parser to hunting for '$' with empty accumulators.
module nmea_rmc_position_parser import nrmc_pkg::*; #(
  parameter int MaxFieldChars = 12,
  parameter int FracDigits    = 5
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [ValueW-1:0]  latitude_value_o,
  output logic signed [ValueW-1:0]  longitude_value_o,
  output logic [StatusW-1:0]        parse_status_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  result_t    result_q;

  logic       core_emit;
  result_t    core_result;
  logic       core_take;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign core_take  = in_valid_q && (!core_emit || out_free);
  assign in_ready_o = !in_valid_q || core_take;

  nrmc_parse_core #(
    .MaxFieldChars(MaxFieldChars),
    .FracDigits   (FracDigits)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (core_take),
    .char_i  (in_byte_q),
    .emit_o  (core_emit),
    .result_o(core_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_take && core_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_take && core_emit) begin
      result_q <= core_result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign latitude_value_o  = result_q.lat;
  assign longitude_value_o = result_q.lon;
  assign parse_status_o    = result_q.status;

endmodule

// File: hw/rtl/nrmc_field_unit.sv
// Digit accumulate step and closing scale for one numeric field.
module nrmc_field_unit import nrmc_pkg::*; #(
  parameter int MaxFieldChars = 12,
  parameter int FracDigits    = 5
) (
  input  logic [7:0]      char_i,
  input  logic [AccW-1:0] acc_i,
  input  field_t          field_i,
  output logic [AccW-1:0] acc_feed_o,
  output field_t          field_feed_o,
  output logic [AccW-1:0] acc_final_o
);

  localparam int ScaleExp = FracDigits - 2;
  localparam int KeepFrac = (ScaleExp > 0) ? ScaleExp : 0;
  localparam logic [CharsW-1:0] MaxChars = CharsW'(MaxFieldChars);
  localparam logic [FracW-1:0]  KeepW    = FracW'(KeepFrac);

  logic             is_digit;
  logic [3:0]       digit;
  logic [AccW+3:0]  mac;
  logic [AccW-1:0]  acc_sat;

  assign is_digit = (char_i >= ChZero) && (char_i <= ChNine);
  assign digit    = 4'(char_i - ChZero);
  // acc*10 + d, saturating
  assign mac      = ({4'b0, acc_i} << 3) + ({4'b0, acc_i} << 1) + (AccW+4)'(digit);
  assign acc_sat  = (mac > (AccW+4)'(SatMax)) ? SatMax : mac[AccW-1:0];

  always_comb begin
    acc_feed_o   = acc_i;
    field_feed_o = field_i;
    if (field_i.chars < MaxChars) begin
      field_feed_o.chars = field_i.chars + 1'b1;
      if (!field_i.stopped) begin
        if (is_digit) begin
          if (!field_i.point) begin
            acc_feed_o = acc_sat;
          end else if (field_i.frac < KeepW) begin
            acc_feed_o        = acc_sat;
            field_feed_o.frac = field_i.frac + 1'b1;
          end
        end else if ((char_i == ChPoint) && !field_i.point) begin
          field_feed_o.point = 1'b1;
        end else begin
          field_feed_o.stopped = 1'b1;
        end
      end
    end
  end

  generate
    if (ScaleExp < 0) begin : g_div10
      // x/10 by reciprocal multiply, exact for 32-bit x
      logic [AccW+31:0] recip_prod;
      assign recip_prod  = {32'b0, acc_i} * {{AccW{1'b0}}, 32'hcccccccd};
      assign acc_final_o = AccW'(recip_prod[AccW+31:35]);
    end else begin : g_scale
      localparam logic [FracW-1:0] ScaleW = FracW'(ScaleExp);
      logic [AccW+PowW-1:0] prod;
      assign prod        = {{PowW{1'b0}}, acc_i} * {{AccW{1'b0}}, pow10(ScaleW - field_i.frac)};
      assign acc_final_o = (prod > (AccW+PowW)'(SatMax)) ? SatMax : prod[AccW-1:0];
    end
  endgenerate

endmodule

// File: hw/rtl/nrmc_parse_core.sv
// Sentence state machine with latitude/longitude accumulators.
module nrmc_parse_core import nrmc_pkg::*; #(
  parameter int MaxFieldChars = 12,
  parameter int FracDigits    = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_i,
  output logic       emit_o,
  output result_t    result_o
);

  phase_e          phase_q, phase_d;
  logic [AccW-1:0] lat_q, lat_d, lon_q, lon_d;
  field_t          field_q, field_d;
  logic            lat_neg_q, lat_neg_d;

  logic [AccW-1:0]   acc_sel, acc_feed, acc_final;
  field_t            field_feed;
  logic [ValueW-1:0] lat_mag, lat_signed, lon_mag;

  assign acc_sel = (phase_q == PH_LON) ? lon_q : lat_q;

  nrmc_field_unit #(
    .MaxFieldChars(MaxFieldChars),
    .FracDigits   (FracDigits)
  ) u_field (
    .char_i      (char_i),
    .acc_i       (acc_sel),
    .field_i     (field_q),
    .acc_feed_o  (acc_feed),
    .field_feed_o(field_feed),
    .acc_final_o (acc_final)
  );

  assign lat_mag    = {1'b0, lat_q};
  assign lat_signed = lat_neg_q ? (ValueW'(0) - lat_mag) : lat_mag;
  assign lon_mag    = {1'b0, lon_q};

  always_comb begin
    phase_d   = phase_q;
    lat_d     = lat_q;
    lon_d     = lon_q;
    field_d   = field_q;
    lat_neg_d = lat_neg_q;
    emit_o    = 1'b0;
    result_o  = '{lat: '0, lon: '0, status: ST_OK};
    case (phase_q)
      PH_HUNT: begin
        if (char_i == ChDollar) begin
          lat_d     = '0;
          lon_d     = '0;
          lat_neg_d = 1'b0;
          field_d   = '0;
          phase_d   = PH_HDR0;
        end
      end
      PH_HDR0, PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4, PH_HDR5: begin
        if (char_i != hdr_char(phase_q)) begin
          emit_o          = 1'b1;
          result_o.status = ST_HEADER;
          phase_d         = PH_HUNT;
        end else begin
          phase_d = phase_e'(phase_q + 4'd1);  // last header step lands on skip
        end
      end
      PH_SKIP: begin
        if (char_i == ChA) begin
          phase_d = PH_DROP;
        end
      end
      PH_DROP: begin
        phase_d = PH_LAT;
      end
      PH_LAT: begin
        if (char_i == ChComma) begin
          lat_d   = acc_final;
          phase_d = PH_NS;
        end else begin
          lat_d   = acc_feed;
          field_d = field_feed;
        end
      end
      PH_NS: begin
        if ((char_i == ChN) || (char_i == ChS)) begin
          lat_neg_d = (char_i == ChS);
          phase_d   = PH_COMMA;
        end else begin
          emit_o          = 1'b1;
          result_o.lat    = lat_mag;
          result_o.status = ST_BAD_NS;
          phase_d         = PH_HUNT;
        end
      end
      PH_COMMA: begin
        if (char_i == ChComma) begin
          field_d = '0;
          phase_d = PH_LON;
        end else begin
          emit_o          = 1'b1;
          result_o.lat    = lat_signed;
          result_o.status = ST_NO_COMMA;
          phase_d         = PH_HUNT;
        end
      end
      PH_LON: begin
        if (char_i == ChComma) begin
          lon_d   = acc_final;
          phase_d = PH_EW;
        end else begin
          lon_d   = acc_feed;
          field_d = field_feed;
        end
      end
      PH_EW: begin
        emit_o       = 1'b1;
        result_o.lat = lat_signed;
        phase_d      = PH_HUNT;
        if (char_i == ChW) begin
          result_o.lon = ValueW'(0) - lon_mag;
        end else begin
          result_o.lon = lon_mag;
        end
        if ((char_i != ChE) && (char_i != ChW)) begin
          result_o.status = ST_BAD_EW;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      lat_q     <= '0;
      lon_q     <= '0;
      field_q   <= '0;
      lat_neg_q <= 1'b0;
    end else if (take_i) begin
      phase_q   <= phase_d;
      lat_q     <= lat_d;
      lon_q     <= lon_d;
      field_q   <= field_d;
      lat_neg_q <= lat_neg_d;
    end
  end

endmodule
